>>> hdl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants of the priority message queue: transaction
// payloads, queue entry layout, configuration set and status codes.
// ----------------------------------------------------------------------------
package pmq_pkg;

    // field widths
    localparam int PRIO_W       = 15;
    localparam int LEN_W        = 16;
    localparam int TAG_W        = 32;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 5;
    localparam int CFG_MAXMSG_W = 5;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;

    // default queue depth
    localparam int DEFAULT_CAPACITY = 16;

    // configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0]  REG_MAX_MESSAGES     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0]  REG_MAX_MESSAGE_SIZE = 1'd1;
    localparam logic [CFG_MAXMSG_W-1:0] RST_MAX_MESSAGES     = 5'd10;
    localparam logic [LEN_W-1:0]        RST_MAX_MESSAGE_SIZE = 16'd1024;

    // operation codes
    localparam logic FUNC_SEND    = 1'b0;
    localparam logic FUNC_RECEIVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SMALL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    // input transaction
    typedef struct packed {
        logic              func;
        logic [PRIO_W-1:0] priority_req;
        logic [LEN_W-1:0]  length;
        logic [TAG_W-1:0]  message_tag;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    out_tag;
        logic [LEN_W-1:0]    out_length;
        logic [PRIO_W-1:0]   out_priority;
        logic [COUNT_W-1:0]  message_count;
    } t_out_item;

    // one held message
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [LEN_W-1:0]  length;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // live configuration
    typedef struct packed {
        logic [CFG_MAXMSG_W-1:0] max_messages;
        logic [LEN_W-1:0]        max_message_size;
    } t_cfg;

endpackage

>>> hdl/pmq_store.sv
// ----------------------------------------------------------------------------
// pmq_store
// Entry memory of the queue: one write port and one read port with a
// registered read, index 0 holds the head message.
// ----------------------------------------------------------------------------
module pmq_store
    import pmq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(CAPACITY)-1:0] i_waddr,
    input  t_entry                      i_wdata,
    input  logic [$clog2(CAPACITY)-1:0] i_raddr,
    output t_entry                      o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// pmq_ctrl
// Sequencer of the queue: limit checks, insertion scan from the tail with
// one priority compare per step, head removal with one move per step,
// and the output register.
// ----------------------------------------------------------------------------
module pmq_ctrl
    import pmq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  t_in_item                    i_in_data,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output t_out_item                   o_out_data,
    // entry memory
    output logic                        o_mem_we,
    output logic [$clog2(CAPACITY)-1:0] o_mem_waddr,
    output t_entry                      o_mem_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_mem_raddr,
    input  t_entry                      i_mem_rdata
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > CFG_MAXMSG_W) ? CW : CFG_MAXMSG_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SCMP  = 3'd3;
    localparam logic [2:0] S_RHEAD = 3'd4;
    localparam logic [2:0] S_RREAD = 3'd5;
    localparam logic [2:0] S_RMOVE = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_held, n_held;
    logic [CW-1:0]       r_k, n_k;
    t_in_item            r_item, n_item;
    logic [STATUS_W-1:0] r_status, n_status;
    t_entry              r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic [CW-1:0]       w_km1;
    logic                w_full;
    t_entry              w_new;

    assign w_km1  = r_k - CW'(1);
    assign w_full = (CMPW'(r_held) >= CMPW'(i_cfg.max_messages)) ||
                    (r_held == CW'(CAPACITY));
    assign w_new  = '{prio: r_item.priority_req, length: r_item.length,
                      tag: r_item.message_tag};

    // next state and memory port control
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_k         = r_k;
        n_item      = r_item;
        n_status    = r_status;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = w_new;
        o_mem_raddr = '0;

        // output transaction taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_CHECK;
                end
            end
            // limit checks, head read issued for a receive
            S_CHECK: begin
                n_res = '0;
                if (r_item.func == FUNC_SEND) begin
                    if (r_item.length > i_cfg.max_message_size) begin
                        n_status = ST_TOO_LONG;
                        n_state  = S_FIN;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else begin
                        n_status = ST_OK;
                        n_k      = r_held;
                        n_state  = S_SCAN;
                    end
                end else begin
                    if (r_item.length < i_cfg.max_message_size) begin
                        n_status = ST_SMALL;
                        n_state  = S_FIN;
                    end else if (r_held == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_FIN;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_RHEAD;
                    end
                end
            end
            // insertion: read the entry in front of the hole, or write the new one at the head
            S_SCAN: begin
                if (r_k == '0) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = '0;
                    n_held      = r_held + CW'(1);
                    n_state     = S_FIN;
                end else begin
                    o_mem_raddr = w_km1[AW-1:0];
                    n_state     = S_SCMP;
                end
            end
            // insertion: lower priority moves back, otherwise drop in the new one
            S_SCMP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_k[AW-1:0];
                if (i_mem_rdata.prio < r_item.priority_req) begin
                    o_mem_wdata = i_mem_rdata;
                    n_k         = w_km1;
                    n_state     = S_SCAN;
                end else begin
                    n_held  = r_held + CW'(1);
                    n_state = S_FIN;
                end
            end
            // removal: capture the head
            S_RHEAD: begin
                n_res   = i_mem_rdata;
                n_k     = CW'(1);
                n_state = S_RREAD;
            end
            S_RREAD: begin
                if (r_k >= r_held) begin
                    n_held  = r_held - CW'(1);
                    n_state = S_FIN;
                end else begin
                    o_mem_raddr = r_k[AW-1:0];
                    n_state     = S_RMOVE;
                end
            end
            // removal: move one entry towards the head
            S_RMOVE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = w_km1[AW-1:0];
                o_mem_wdata = i_mem_rdata;
                n_k         = r_k + CW'(1);
                n_state     = S_RREAD;
            end
            // hand the result to the output register once it is free
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: r_status, out_tag: r_res.tag,
                                    out_length: r_res.length,
                                    out_priority: r_res.prio,
                                    message_count: COUNT_W'(r_held)};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_item   <= n_item;
        r_status <= n_status;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted transaction holds off the next one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("pmq_ctrl: input taken twice in a row");

    // held count only moves on the way into the finish state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != $past(r_held) |-> r_state == S_FIN)
        else $error("pmq_ctrl: held count changed outside completion");

    // held count stays within the memory
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(CAPACITY))
        else $error("pmq_ctrl: held count beyond capacity");

    // memory writes only happen in the insertion and removal steps
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> r_state == S_SCAN || r_state == S_SCMP || r_state == S_RMOVE)
        else $error("pmq_ctrl: memory write outside a shift step");

    // failed transactions report no message
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.out_tag == '0 && o_out_data.out_length == '0)
        else $error("pmq_ctrl: failed transaction carries message fields");

endmodule

>>> hdl/priority_message_queue_core.sv
// ----------------------------------------------------------------------------
// priority_message_queue_core
// Bounded message queue kept in priority order, highest first, with equal
// priorities leaving in arrival order.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a send carries a
// priority, a length and a tag; a receive carries the buffer size in the
// length field. Output channel (o_out_valid / i_out_stall / o_out_data):
// one result per transaction with status, the received message and the
// number of messages held afterwards.
// One transaction is in flight at a time; o_in_stall is high until its
// result sits in the output register. A failed check goes straight to the
// finish state. A send scans from the tail, moving each held message of
// lower priority back by one before the new message is written; a receive
// captures the head and moves each remaining message one place towards it.
// Each moved message costs one read and one write of the entry memory.
// A result waiting on i_out_stall does not block the next transaction,
// which finishes into the output register once it is taken.
// Reset empties the queue and restores max_messages to 10 and
// max_message_size to 1024; configuration is written through i_cfg_we.
// ----------------------------------------------------------------------------
module priority_message_queue_core
    import pmq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data
);

    localparam int AW = $clog2(CAPACITY);

    t_cfg          r_cfg;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [AW-1:0] w_mem_raddr;
    t_entry        w_mem_wdata;
    t_entry        w_mem_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_messages     <= RST_MAX_MESSAGES;
            r_cfg.max_message_size <= RST_MAX_MESSAGE_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_MESSAGES:     r_cfg.max_messages     <= i_cfg_data[CFG_MAXMSG_W-1:0];
                REG_MAX_MESSAGE_SIZE: r_cfg.max_message_size <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    pmq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // entry memory
    pmq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for priority_message_queue_core. A mirror of the queue
// predicts the result of every accepted transaction, and each result taken
// from the block is compared field by field with the oldest prediction.
// Directed cases cover check order and limit edges. Random traffic then sweeps
// several queue settings under three patterns of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import pmq_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 50;
    localparam int MAX_REPORTS  = 10;
    localparam int N_SETTINGS   = 6;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_item               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_item              o_out_data;

    // queue settings swept by random traffic, with transactions per setting
    int sweep_limit [N_SETTINGS] = '{31, 16, 4, 10, 1, 0};
    int sweep_size  [N_SETTINGS] = '{65535, 1, 0, 1024, 40000, 100};
    int sweep_items [N_SETTINGS] = '{70, 15, 12, 15, 8, 6};

    // mirror of the held messages and the live limits
    t_entry                  queued_msgs[$];
    logic [CFG_MAXMSG_W-1:0] model_max_messages = RST_MAX_MESSAGES;
    logic [LEN_W-1:0]        model_max_size     = RST_MAX_MESSAGE_SIZE;

    t_out_item pending_replies[$];
    int        mismatch_count     = 0;
    int        idle_cycles        = 0;
    int        sender_idle_pct    = 0;
    int        receiver_stall_pct = 0;

    priority_message_queue_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // apply one transaction to the mirror and return its result
    function automatic t_out_item apply_queue_op(input t_in_item item);
        t_out_item   reply;
        t_entry      msg;
        int unsigned limit;
        int unsigned pos;
        reply = '0;
        limit = (model_max_messages < CAPACITY) ? model_max_messages : CAPACITY;
        if (item.func == FUNC_SEND) begin
            if (item.length > model_max_size) begin
                reply.status = ST_TOO_LONG;
            end else if (queued_msgs.size() >= limit) begin
                reply.status = ST_FULL;
            end else begin
                // goes behind every held message of equal or higher priority
                pos = 0;
                while (pos < queued_msgs.size() && queued_msgs[pos].prio >= item.priority_req)
                    pos++;
                msg.prio   = item.priority_req;
                msg.length = item.length;
                msg.tag    = item.message_tag;
                queued_msgs.insert(pos, msg);
                reply.status = ST_OK;
            end
        end else begin
            if (item.length < model_max_size) begin
                reply.status = ST_SMALL;
            end else if (queued_msgs.size() == 0) begin
                reply.status = ST_EMPTY;
            end else begin
                msg                = queued_msgs.pop_front();
                reply.status       = ST_OK;
                reply.out_tag      = msg.tag;
                reply.out_length   = msg.length;
                reply.out_priority = msg.prio;
            end
        end
        reply.message_count = COUNT_W'(queued_msgs.size());
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: expected st %0d tag %h len %0d prio %0d cnt %0d", $time, what,
                     want.status, want.out_tag, want.out_length, want.out_priority,
                     want.message_count,
                     "\n    got st %0d tag %h len %0d prio %0d cnt %0d",
                     got.status, got.out_tag, got.out_length, got.out_priority,
                     got.message_count);
    endtask

    // configuration mirror
    always @(posedge i_clk) begin
        if (i_cfg_we) begin
            if (i_cfg_index == REG_MAX_MESSAGES)
                model_max_messages <= i_cfg_data[CFG_MAXMSG_W-1:0];
            else if (i_cfg_index == REG_MAX_MESSAGE_SIZE)
                model_max_size <= i_cfg_data[LEN_W-1:0];
        end
    end

    // predict on every accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            pending_replies.push_back(apply_queue_op(i_in_data));
    end

    // compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_replies
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("result with nothing pending", '0, o_out_data);
            end else begin
                want = pending_replies.pop_front();
                if (o_out_data.status !== want.status
                        || o_out_data.out_tag !== want.out_tag
                        || o_out_data.out_length !== want.out_length
                        || o_out_data.out_priority !== want.out_priority
                        || o_out_data.message_count !== want.message_count)
                    report_mismatch("result mismatch", want, o_out_data);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // offer one transaction, with random gaps ahead of it
    task automatic send_item(input logic func, input logic [PRIO_W-1:0] prio,
                             input logic [LEN_W-1:0] len, input logic [TAG_W-1:0] tag);
        t_in_item item;
        item.func         = func;
        item.priority_req = prio;
        item.length       = len;
        item.message_tag  = tag;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // hold off the sender until every predicted result has been taken
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // write both limits once the block is idle
    task automatic configure_queue(input int limit, input int size);
        logic [CFG_DATA_W-1:0] limit_word;
        // bits above the register width are dropped by the block
        limit_word = CFG_DATA_W'($urandom);
        limit_word[CFG_MAXMSG_W-1:0] = limit[CFG_MAXMSG_W-1:0];
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAX_MESSAGES;
        i_cfg_data  <= limit_word;
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_MESSAGE_SIZE;
        i_cfg_data  <= size[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // check order, field extremes and equal priority ordering at reset limits
    task automatic test_basic_ops();
        // buffer too small wins over queue empty
        send_item(FUNC_RECEIVE, '0, LEN_W'(RST_MAX_MESSAGE_SIZE - 1), '0);
        send_item(FUNC_RECEIVE, '1, RST_MAX_MESSAGE_SIZE, '1);
        send_item(FUNC_SEND, 15'd7, LEN_W'(RST_MAX_MESSAGE_SIZE + 1), 32'h1234_5678);
        send_item(FUNC_SEND, '0, RST_MAX_MESSAGE_SIZE, '0);
        send_item(FUNC_SEND, '1, '0, '1);
        // equal priorities leave in arrival order
        send_item(FUNC_SEND, 15'd100, 16'd5, 32'hA5A5_0001);
        send_item(FUNC_SEND, 15'd100, 16'd6, 32'h5A5A_0002);
        repeat (4) send_item(FUNC_RECEIVE, '1, '1, '0);
    endtask

    // full queue, lowered and zero limits, zero and largest size limits
    task automatic test_queue_limits();
        configure_queue(2, int'(RST_MAX_MESSAGE_SIZE));
        send_item(FUNC_SEND, 15'd5, 16'd10, 32'h0000_0011);
        send_item(FUNC_SEND, 15'd5, 16'd20, 32'h0000_0022);
        send_item(FUNC_SEND, 15'd9, RST_MAX_MESSAGE_SIZE, 32'h0000_0033);
        // too long is reported ahead of queue full
        send_item(FUNC_SEND, 15'd9, LEN_W'(RST_MAX_MESSAGE_SIZE + 1), 32'h0000_0044);
        // limit lowered below the held count keeps the messages
        configure_queue(1, int'(RST_MAX_MESSAGE_SIZE));
        send_item(FUNC_SEND, 15'd1, 16'd1, 32'h0000_0055);
        send_item(FUNC_RECEIVE, '0, RST_MAX_MESSAGE_SIZE, '0);
        send_item(FUNC_SEND, 15'd1, 16'd1, 32'h0000_0066);
        send_item(FUNC_RECEIVE, '0, RST_MAX_MESSAGE_SIZE, '0);
        send_item(FUNC_SEND, 15'd3, 16'd2, 32'h0000_0077);
        // zero limit refuses every send
        configure_queue(0, int'(RST_MAX_MESSAGE_SIZE));
        send_item(FUNC_SEND, 15'd3, 16'd0, 32'h0000_0088);
        send_item(FUNC_RECEIVE, '0, LEN_W'(RST_MAX_MESSAGE_SIZE - 1), '0);
        send_item(FUNC_RECEIVE, '0, RST_MAX_MESSAGE_SIZE, '0);
        // zero size limit: only empty messages, any buffer
        configure_queue(31, 0);
        send_item(FUNC_SEND, 15'd2, 16'd0, 32'hDEAD_BEEF);
        send_item(FUNC_SEND, 15'd2, 16'd1, 32'hDEAD_BEF0);
        send_item(FUNC_RECEIVE, '0, 16'd0, '0);
        // largest size limit
        configure_queue(31, 65535);
        send_item(FUNC_SEND, '1, '1, 32'hCAFE_F00D);
        send_item(FUNC_RECEIVE, '0, 16'hFFFE, '0);
        send_item(FUNC_RECEIVE, '0, 16'hFFFF, '0);
    endtask

    // random traffic over every setting, mostly well-formed transactions
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int                send_pct;
        logic              func;
        logic [PRIO_W-1:0] prio;
        logic [LEN_W-1:0]  len;
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        for (int s = 0; s < N_SETTINGS; s++) begin
            configure_queue(sweep_limit[s], sweep_size[s]);
            for (int n = 0; n < sweep_items[s]; n++) begin
                // fill for the first two thirds, then mostly drain
                send_pct = (n < sweep_items[s] * 2 / 3) ? 80 : 25;
                func = ($urandom_range(99) < send_pct) ? FUNC_SEND : FUNC_RECEIVE;
                // few distinct priorities give plenty of ties
                case ($urandom_range(3))
                    0: prio = PRIO_W'($urandom_range(3));
                    1: prio = $urandom_range(1) ? '1 : '0;
                    default: prio = PRIO_W'($urandom_range(32767));
                endcase
                if ($urandom_range(99) >= 85)
                    len = LEN_W'($urandom_range(65535));
                else if (func == FUNC_SEND)
                    len = LEN_W'($urandom_range(sweep_size[s], 0));
                else
                    len = LEN_W'($urandom_range(65535, sweep_size[s]));
                send_item(func, prio, len, $urandom);
            end
        end
    endtask

    // test sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sender_idle_pct    = 12;
        receiver_stall_pct = 76;
        test_basic_ops();
        test_queue_limits();
        test_random_traffic(12, 76);
        test_random_traffic(76, 12);
        test_random_traffic(0, 0);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
